### design/bfd_pkg.sv
// ----------------------------------------------------------------------------
// bfd_pkg
// shared types and constants for the cubic bezier forward difference generator
// ----------------------------------------------------------------------------
package bfd_pkg;

   localparam int MAX_QUALITY = 5;
   localparam int BQ_W        = 3;
   localparam int STEP_W      = MAX_QUALITY + 1;
   localparam int QMAX        = 3 * MAX_QUALITY;
   localparam int SH_W        = $clog2(QMAX + 1);
   localparam int Q_W         = MAX_QUALITY + 3;
   localparam int QD_W        = MAX_QUALITY + 2;
   localparam int COORD_W     = 16;
   localparam int ACC_W       = 32;
   localparam int RAW_W       = 20;
   localparam int WIDE_W      = 40;
   localparam int SUM_W       = ACC_W + 2;

   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 3;

   localparam logic [CSR_INDEX_W-1:0] CSR_QUALITY      = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_PRESCALE_OFF = 1'd1;

   localparam logic [BQ_W-1:0] QUALITY_RESET = 3'd5;

   localparam logic signed [COORD_W-1:0] BOUND_LOW_RESET  = 16'sh7fff;
   localparam logic signed [COORD_W-1:0] BOUND_HIGH_RESET = 16'sh0000;

   localparam logic signed [SUM_W-1:0] ACC_LIMIT  = 34'sh0_3fff_fffe;
   localparam logic signed [ACC_W-1:0] NORM_LIMIT = 32'sh4000_0000;
   localparam logic [ACC_W-1:0]        INIT_LIMIT = 32'h7fff_ffff;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PREP,
      ST_SCALE,
      ST_RUN,
      ST_FINAL
   } state_type;

   typedef struct packed {
      logic load;
      logic prep;
      logic scale;
      logic step;
      logic emit_end;
   } bfd_cmd_type;

endpackage

### design/bfd_lane.sv
// ----------------------------------------------------------------------------
// bfd_lane
// one axis of the forward difference engine: difference setup, adaptive
// fixed point scale and one curve point per step
// ----------------------------------------------------------------------------
module bfd_lane import bfd_pkg::*; (
   input  logic                       clock,
   input  bfd_cmd_type                cmd,
   input  logic [BQ_W-1:0]            bq,
   input  logic                       prescale_off,
   input  logic signed [COORD_W-1:0]  start_val,
   input  logic signed [COORD_W-1:0]  ctrl_one_val,
   input  logic signed [COORD_W-1:0]  ctrl_two_val,
   input  logic signed [COORD_W-1:0]  end_val,
   output logic signed [COORD_W-1:0]  point
);

   logic signed [COORD_W-1:0] p0_ff, p1_ff, p2_ff, p3_ff;
   logic signed [ACC_W-1:0]   d1_ff, d2_ff, d3_ff, pos_ff;
   logic signed [Q_W-1:0]     q_ff;
   logic [QD_W-1:0]           qd_ff;

   logic signed [ACC_W-1:0]   d1_in, d2_in, d3_in, pos_in;
   logic signed [Q_W-1:0]     q_in;
   logic [QD_W-1:0]           qd_in;

   // setup
   logic signed [RAW_W-1:0]   e1, e2o, e2, e3;
   logic                      halve;
   logic [SH_W-1:0]           q0;
   logic [SH_W-1:0]           q_fit;
   logic [COORD_W:0]          p0_mag;
   logic [QMAX:1]             fits;

   // scale
   logic signed [WIDE_W-1:0]  t1, t2, t3, t6;
   logic signed [ACC_W-1:0]   sd3;

   // step
   logic signed [ACC_W-1:0]   half, d1a, d1b, pos_a, pos_b, pos_mid, scaled;
   logic signed [SUM_W-1:0]   s;
   logic [QD_W:0]             qd_p1;
   logic [QD_W-1:0]           qd_mid;
   logic signed [Q_W-1:0]     q_mid;
   logic                      big, norm_a, norm_b, renorm;

   always_comb begin
      // raw differences
      e1    = RAW_W'(p1_ff) - RAW_W'(p0_ff);
      e2o   = RAW_W'(p2_ff) - RAW_W'(p1_ff);
      e2    = e2o - e1;
      e3    = RAW_W'(p3_ff) - RAW_W'(p0_ff) - 20'sd3 * e2o;
      halve = !prescale_off && (bq != '0);
      if (halve) begin
         e1 = e1 >>> 1;
         e2 = e2 >>> 1;
         e3 = e3 >>> 1;
      end
      q0 = SH_W'({bq, 1'b0}) + SH_W'(bq) - SH_W'(halve);

      // starting scale: largest exponent that keeps the start point in range
      p0_mag = p0_ff[COORD_W-1] ? (COORD_W+1)'(-(COORD_W+1)'(p0_ff))
                                : (COORD_W+1)'(p0_ff);
      for (int i = 1; i <= QMAX; i++) begin
         fits[i] = ACC_W'(p0_mag) < (INIT_LIMIT >> i);
      end
      q_fit = '0;
      for (int i = 1; i <= QMAX; i++) begin
         if ((SH_W'(i) <= q0) && fits[i]) begin
            q_fit = SH_W'(i);
         end
      end

      // scaled differences
      t1  = (WIDE_W'(d1_ff) * 40'sd3) <<< {bq, 1'b0};
      t2  = (WIDE_W'(d2_ff) * 40'sd3) <<< bq;
      t3  = WIDE_W'(d3_ff);
      t6  = WIDE_W'(d3_ff) * 40'sd6;
      sd3 = ACC_W'(t6);

      // one forward difference step
      scaled  = (q_ff > 0) ? (pos_ff >>> q_ff[SH_W-1:0]) : pos_ff;
      half    = pos_ff >>> 1;
      qd_p1   = (QD_W+1)'(qd_ff) + 1'b1;
      d1a     = d1_ff >>> qd_ff;
      d1b     = d1_ff >>> qd_p1;
      s       = SUM_W'(half) + SUM_W'(d1b);
      big     = (s >= ACC_LIMIT) || (s <= -ACC_LIMIT);
      pos_a   = pos_ff + d1a;
      pos_b   = s[ACC_W-1:0];
      norm_a  = (pos_a > -NORM_LIMIT) && (pos_a < NORM_LIMIT);
      norm_b  = (pos_b > -NORM_LIMIT) && (pos_b < NORM_LIMIT);
      pos_mid = big ? pos_b : pos_a;
      qd_mid  = qd_ff + QD_W'(big);
      q_mid   = q_ff - Q_W'(big);
      renorm  = (qd_mid != '0) && (big ? norm_b : norm_a);

      d1_in  = d1_ff;
      d2_in  = d2_ff;
      d3_in  = d3_ff;
      pos_in = pos_ff;
      q_in   = q_ff;
      qd_in  = qd_ff;
      priority if (cmd.prep) begin
         d1_in = ACC_W'(e1);
         d2_in = ACC_W'(e2);
         d3_in = ACC_W'(e3);
         q_in  = Q_W'(q_fit);
         qd_in = QD_W'(q0 - q_fit);
      end else if (cmd.scale) begin
         d1_in  = ACC_W'(t1 + t2 + t3);
         d3_in  = sd3;
         d2_in  = ACC_W'(((WIDE_W'(d2_ff) * 40'sd6) <<< bq) + WIDE_W'(sd3));
         pos_in = (ACC_W'(p0_ff) <<< q_ff[SH_W-1:0])
                + ((32'sd1 <<< q_ff[SH_W-1:0]) >>> 1);
      end else if (cmd.step) begin
         pos_in = renorm ? {pos_mid[ACC_W-2:0], 1'b1} : pos_mid;
         q_in   = q_mid + Q_W'(renorm);
         qd_in  = qd_mid - QD_W'(renorm);
         d1_in  = d1_ff + d2_ff;
         d2_in  = d2_ff + d3_ff;
      end
   end

   assign point = cmd.emit_end ? p3_ff : scaled[COORD_W-1:0];

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         p0_ff <= start_val;
         p1_ff <= ctrl_one_val;
         p2_ff <= ctrl_two_val;
         p3_ff <= end_val;
      end
      d1_ff  <= d1_in;
      d2_ff  <= d2_in;
      d3_ff  <= d3_in;
      pos_ff <= pos_in;
      q_ff   <= q_in;
      qd_ff  <= qd_in;
   end

endmodule

### design/bfd_datapath.sv
// ----------------------------------------------------------------------------
// bfd_datapath
// two axis lanes, running bounds and the result word register
// ----------------------------------------------------------------------------
module bfd_datapath import bfd_pkg::*; (
   input  logic                       clock,
   input  logic                       reset,
   input  bfd_cmd_type                cmd,
   input  logic [BQ_W-1:0]            bq,
   input  logic                       prescale_off,
   input  logic signed [COORD_W-1:0]  req_start_x,
   input  logic signed [COORD_W-1:0]  req_ctrl_one_x,
   input  logic signed [COORD_W-1:0]  req_ctrl_two_x,
   input  logic signed [COORD_W-1:0]  req_end_x,
   input  logic signed [COORD_W-1:0]  req_start_y,
   input  logic signed [COORD_W-1:0]  req_ctrl_one_y,
   input  logic signed [COORD_W-1:0]  req_ctrl_two_y,
   input  logic signed [COORD_W-1:0]  req_end_y,
   input  logic                       req_restart_bounds,
   output logic signed [COORD_W-1:0]  rsp_point_x,
   output logic signed [COORD_W-1:0]  rsp_point_y,
   output logic                       rsp_last_point,
   output logic signed [COORD_W-1:0]  rsp_min_x,
   output logic signed [COORD_W-1:0]  rsp_min_y,
   output logic signed [COORD_W-1:0]  rsp_max_x,
   output logic signed [COORD_W-1:0]  rsp_max_y
);

   logic signed [COORD_W-1:0] pt_x, pt_y;
   logic signed [COORD_W-1:0] lo_x_ff, lo_y_ff, hi_x_ff, hi_y_ff;
   logic signed [COORD_W-1:0] lo_x_in, lo_y_in, hi_x_in, hi_y_in;
   logic signed [COORD_W-1:0] point_x_ff, point_y_ff;
   logic signed [COORD_W-1:0] min_x_ff, min_y_ff, max_x_ff, max_y_ff;
   logic                      last_ff;
   logic                      emit;

   bfd_lane u_lane_x (
      .clock        (clock),
      .cmd          (cmd),
      .bq           (bq),
      .prescale_off (prescale_off),
      .start_val    (req_start_x),
      .ctrl_one_val (req_ctrl_one_x),
      .ctrl_two_val (req_ctrl_two_x),
      .end_val      (req_end_x),
      .point        (pt_x)
   );

   bfd_lane u_lane_y (
      .clock        (clock),
      .cmd          (cmd),
      .bq           (bq),
      .prescale_off (prescale_off),
      .start_val    (req_start_y),
      .ctrl_one_val (req_ctrl_one_y),
      .ctrl_two_val (req_ctrl_two_y),
      .end_val      (req_end_y),
      .point        (pt_y)
   );

   assign emit = cmd.step || cmd.emit_end;

   always_comb begin
      lo_x_in = (pt_x < lo_x_ff) ? pt_x : lo_x_ff;
      lo_y_in = (pt_y < lo_y_ff) ? pt_y : lo_y_ff;
      hi_x_in = (pt_x > hi_x_ff) ? pt_x : hi_x_ff;
      hi_y_in = (pt_y > hi_y_ff) ? pt_y : hi_y_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lo_x_ff <= BOUND_LOW_RESET;
         lo_y_ff <= BOUND_LOW_RESET;
         hi_x_ff <= BOUND_HIGH_RESET;
         hi_y_ff <= BOUND_HIGH_RESET;
      end else if (cmd.load && req_restart_bounds) begin
         lo_x_ff <= BOUND_LOW_RESET;
         lo_y_ff <= BOUND_LOW_RESET;
         hi_x_ff <= BOUND_HIGH_RESET;
         hi_y_ff <= BOUND_HIGH_RESET;
      end else if (emit) begin
         lo_x_ff <= lo_x_in;
         lo_y_ff <= lo_y_in;
         hi_x_ff <= hi_x_in;
         hi_y_ff <= hi_y_in;
      end
   end

   // result word
   always_ff @(posedge clock) begin
      if (emit) begin
         point_x_ff <= pt_x;
         point_y_ff <= pt_y;
         last_ff    <= cmd.emit_end;
         min_x_ff   <= lo_x_in;
         min_y_ff   <= lo_y_in;
         max_x_ff   <= hi_x_in;
         max_y_ff   <= hi_y_in;
      end
   end

   assign rsp_point_x    = point_x_ff;
   assign rsp_point_y    = point_y_ff;
   assign rsp_last_point = last_ff;
   assign rsp_min_x      = min_x_ff;
   assign rsp_min_y      = min_y_ff;
   assign rsp_max_x      = max_x_ff;
   assign rsp_max_y      = max_y_ff;

endmodule

### design/bfd_ctrl.sv
// ----------------------------------------------------------------------------
// bfd_ctrl
// sequencer: accepts a curve, runs setup, steps the lanes once per point and
// keeps the result word valid flag
// ----------------------------------------------------------------------------
module bfd_ctrl import bfd_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   input  logic [BQ_W-1:0]   bq,
   output bfd_cmd_type       cmd
);

   state_type          state_ff, state_in;
   logic [STEP_W-1:0]  steps_left_ff, steps_left_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               slot_free;
   logic               emit;

   assign slot_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in      = state_ff;
      steps_left_in = steps_left_ff;
      cmd           = '0;
      req_ready     = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load      = 1'b1;
               steps_left_in = STEP_W'(1) << bq;
               state_in      = ST_PREP;
            end
         end
         ST_PREP: begin
            cmd.prep = 1'b1;
            state_in = ST_SCALE;
         end
         ST_SCALE: begin
            cmd.scale = 1'b1;
            state_in  = ST_RUN;
         end
         ST_RUN: begin
            if (slot_free) begin
               cmd.step      = 1'b1;
               steps_left_in = steps_left_ff - 1'b1;
               if (steps_left_ff == STEP_W'(1)) begin
                  state_in = ST_FINAL;
               end
            end
         end
         ST_FINAL: begin
            if (slot_free) begin
               cmd.emit_end = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign emit         = cmd.step || cmd.emit_end;
   assign rsp_valid_in = emit || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         steps_left_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         steps_left_ff <= steps_left_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   a_cmd_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.load, cmd.prep, cmd.scale, cmd.step, cmd.emit_end}))
      else $error("more than one datapath command");

   a_step_count: assert property (@(posedge clock) disable iff (reset)
      cmd.step |-> (steps_left_ff != '0))
      else $error("step with no points left");

   a_emit_valid: assert property (@(posedge clock) disable iff (reset)
      emit |=> rsp_valid_ff)
      else $error("emitted word not marked valid");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready) |-> !emit)
      else $error("pending word overwritten");

endmodule

### design/cubic_bezier_forward_difference.sv
// ----------------------------------------------------------------------------
// cubic_bezier_forward_difference
// first word: registered on the first run step, after the prep and scale states
// throughput: 2^Q + 1 words per curve, one per cycle while rsp_ready is high;
//   a curve passes through the prep, scale, run and final states, paced by one
//   forward difference step per point in each axis lane
// reset: quality 5, prescale on, bounds min 32767 and max 0, no word pending
// ----------------------------------------------------------------------------
module cubic_bezier_forward_difference import bfd_pkg::*; (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_we,
   input  logic [CSR_INDEX_W-1:0]     csr_index,
   input  logic [CSR_DATA_W-1:0]      csr_wdata,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic signed [COORD_W-1:0]  req_start_x,
   input  logic signed [COORD_W-1:0]  req_ctrl_one_x,
   input  logic signed [COORD_W-1:0]  req_ctrl_two_x,
   input  logic signed [COORD_W-1:0]  req_end_x,
   input  logic signed [COORD_W-1:0]  req_start_y,
   input  logic signed [COORD_W-1:0]  req_ctrl_one_y,
   input  logic signed [COORD_W-1:0]  req_ctrl_two_y,
   input  logic signed [COORD_W-1:0]  req_end_y,
   input  logic                       req_restart_bounds,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic signed [COORD_W-1:0]  rsp_point_x,
   output logic signed [COORD_W-1:0]  rsp_point_y,
   output logic                       rsp_last_point,
   output logic signed [COORD_W-1:0]  rsp_min_x,
   output logic signed [COORD_W-1:0]  rsp_min_y,
   output logic signed [COORD_W-1:0]  rsp_max_x,
   output logic signed [COORD_W-1:0]  rsp_max_y
);

   logic [BQ_W-1:0] quality_ff;
   logic            prescale_off_ff;
   logic [BQ_W-1:0] bq;
   bfd_cmd_type     cmd;

   always_ff @(posedge clock) begin
      if (reset) begin
         quality_ff      <= QUALITY_RESET;
         prescale_off_ff <= 1'b0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_QUALITY:      quality_ff      <= csr_wdata[BQ_W-1:0];
            CSR_PRESCALE_OFF: prescale_off_ff <= csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   // quality capped at the supported maximum
   assign bq = (quality_ff > BQ_W'(MAX_QUALITY)) ? BQ_W'(MAX_QUALITY) : quality_ff;

   bfd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .bq        (bq),
      .cmd       (cmd)
   );

   bfd_datapath u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .bq                 (bq),
      .prescale_off       (prescale_off_ff),
      .req_start_x        (req_start_x),
      .req_ctrl_one_x     (req_ctrl_one_x),
      .req_ctrl_two_x     (req_ctrl_two_x),
      .req_end_x          (req_end_x),
      .req_start_y        (req_start_y),
      .req_ctrl_one_y     (req_ctrl_one_y),
      .req_ctrl_two_y     (req_ctrl_two_y),
      .req_end_y          (req_end_y),
      .req_restart_bounds (req_restart_bounds),
      .rsp_point_x        (rsp_point_x),
      .rsp_point_y        (rsp_point_y),
      .rsp_last_point     (rsp_last_point),
      .rsp_min_x          (rsp_min_x),
      .rsp_min_y          (rsp_min_y),
      .rsp_max_x          (rsp_max_x),
      .rsp_max_y          (rsp_max_y)
   );

endmodule

### tb/tb_cubic_bezier_forward_difference.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_cubic_bezier_forward_difference
// drives cubic curves through the forward difference generator under random
// back-pressure on both channels and checks every vertex word, its last-point
// flag and the running bounds, across several quality and prescale settings
// ----------------------------------------------------------------------------
module tb_cubic_bezier_forward_difference;
   import bfd_pkg::*;

   localparam int NPTS        = (1 << MAX_QUALITY) + 1;
   localparam int CYCLE_LIMIT = 400000;
   localparam int NUM_PHASES  = 10;
   localparam int PHASE_ITEMS = 27;

   typedef struct packed {
      logic signed [COORD_W-1:0] sx;
      logic signed [COORD_W-1:0] c1x;
      logic signed [COORD_W-1:0] c2x;
      logic signed [COORD_W-1:0] ex;
      logic signed [COORD_W-1:0] sy;
      logic signed [COORD_W-1:0] c1y;
      logic signed [COORD_W-1:0] c2y;
      logic signed [COORD_W-1:0] ey;
      logic                      restart;
   } curve_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] point_x;
      logic signed [COORD_W-1:0] point_y;
      logic                      last;
      logic signed [COORD_W-1:0] min_x;
      logic signed [COORD_W-1:0] min_y;
      logic signed [COORD_W-1:0] max_x;
      logic signed [COORD_W-1:0] max_y;
   } vertex_type;

   class bezier_scoreboard_type;
      int unsigned               quality;
      bit                        prescale_off;
      logic signed [COORD_W-1:0] low_x, low_y, high_x, high_y;
      logic signed [COORD_W-1:0] axis_pts [2][NPTS];
      vertex_type                vertex_q [$];
      int                        errors;

      function new();
         quality      = 32'(QUALITY_RESET);
         prescale_off = 1'b0;
         low_x        = BOUND_LOW_RESET;
         low_y        = BOUND_LOW_RESET;
         high_x       = BOUND_HIGH_RESET;
         high_y       = BOUND_HIGH_RESET;
         errors       = 0;
      endfunction

      function void write_reg(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
         if (idx == CSR_QUALITY) quality = 32'(data);
         else if (idx == CSR_PRESCALE_OFF) prescale_off = data[0];
      endfunction

      function int pending();
         return vertex_q.size();
      endfunction

      function longint wrap32(longint v);
         int t;
         t = v[31:0];
         return t;
      endfunction

      function longint asr(longint v, int n);
         if (n <= 0) return v;
         if (n > 62) n = 62;
         return v >>> n;
      endfunction

      function longint shl(longint v, int n);
         if (n <= 0) return v;
         if (n > 40) n = 40;
         return v <<< n;
      endfunction

      function longint mag(longint v);
         return (v < 0) ? -v : v;
      endfunction

      // fixed-point forward differencing of one axis
      function void trace_axis(int ax, longint p0, longint p1, longint p2, longint p3,
                               int bq);
         int     q, qd, n, k;
         longint d1, d2, d3, pos;
         q  = 3 * bq;
         qd = 0;
         n  = 1 << bq;
         d1 = p1 - p0;
         d2 = p2 - p1;
         d3 = -p0 - 3 * d2 + p3;
         d2 = d2 - d1;
         if (!prescale_off && bq >= 1) begin
            d1 = asr(d1, 1);
            d2 = asr(d2, 1);
            d3 = asr(d3, 1);
            q--;
         end
         d1 = wrap32(shl(3 * d1, 2 * bq) + shl(3 * d2, bq) + d3);
         d3 = wrap32(6 * d3);
         d2 = wrap32(shl(6 * d2, bq) + d3);
         while (q > 0 && mag(p0) >= (longint'(INIT_LIMIT) >> q)) begin
            q--;
            qd++;
         end
         pos = wrap32(shl(p0, q) + ((q >= 1) ? shl(1, q - 1) : 64'sd0));
         for (k = 0; k < n; k++) begin
            axis_pts[ax][k] = COORD_W'(asr(pos, q));
            if (mag(asr(pos, 1) + asr(d1, qd + 1)) >= longint'(ACC_LIMIT)) begin
               pos = asr(pos, 1);
               q--;
               qd++;
            end
            pos = wrap32(pos + asr(d1, qd));
            if (qd > 0 && mag(pos) < longint'(NORM_LIMIT)) begin
               pos = pos * 2 + 1;
               q++;
               qd--;
            end
            d1 = wrap32(d1 + d2);
            d2 = wrap32(d2 + d3);
         end
         axis_pts[ax][n] = COORD_W'(p3);
      endfunction

      function void note_curve(curve_type c);
         int         bq, n, k;
         vertex_type v;
         bq = (quality > MAX_QUALITY) ? MAX_QUALITY : quality;
         n  = 1 << bq;
         if (c.restart) begin
            low_x  = BOUND_LOW_RESET;
            low_y  = BOUND_LOW_RESET;
            high_x = BOUND_HIGH_RESET;
            high_y = BOUND_HIGH_RESET;
         end
         trace_axis(0, longint'(c.sx), longint'(c.c1x), longint'(c.c2x),
                    longint'(c.ex), bq);
         trace_axis(1, longint'(c.sy), longint'(c.c1y), longint'(c.c2y),
                    longint'(c.ey), bq);
         for (k = 0; k <= n; k++) begin
            if (axis_pts[0][k] < low_x)  low_x  = axis_pts[0][k];
            if (axis_pts[0][k] > high_x) high_x = axis_pts[0][k];
            if (axis_pts[1][k] < low_y)  low_y  = axis_pts[1][k];
            if (axis_pts[1][k] > high_y) high_y = axis_pts[1][k];
            v.point_x = axis_pts[0][k];
            v.point_y = axis_pts[1][k];
            v.last    = (k == n);
            v.min_x   = low_x;
            v.min_y   = low_y;
            v.max_x   = high_x;
            v.max_y   = high_y;
            vertex_q.push_back(v);
         end
      endfunction

      function void compare_field(string name, logic signed [COORD_W:0] e,
                                  logic signed [COORD_W:0] a);
         if (a !== e) begin
            $display("%0t: %s expected %0d actual %0d", $time, name, e, a);
            errors++;
         end
      endfunction

      function void check_vertex(vertex_type got);
         vertex_type want;
         if (vertex_q.size() == 0) begin
            $display("%0t: unexpected word expected none actual x %0d y %0d", $time,
                     got.point_x, got.point_y);
            errors++;
            return;
         end
         want = vertex_q.pop_front();
         compare_field("point_x", (COORD_W+1)'(want.point_x), (COORD_W+1)'(got.point_x));
         compare_field("point_y", (COORD_W+1)'(want.point_y), (COORD_W+1)'(got.point_y));
         compare_field("last_point", (COORD_W+1)'(want.last), (COORD_W+1)'(got.last));
         compare_field("min_x", (COORD_W+1)'(want.min_x), (COORD_W+1)'(got.min_x));
         compare_field("min_y", (COORD_W+1)'(want.min_y), (COORD_W+1)'(got.min_y));
         compare_field("max_x", (COORD_W+1)'(want.max_x), (COORD_W+1)'(got.max_x));
         compare_field("max_y", (COORD_W+1)'(want.max_y), (COORD_W+1)'(got.max_y));
      endfunction
   endclass

   logic                      clock;
   logic                      reset;
   logic                      csr_we;
   logic [CSR_INDEX_W-1:0]    csr_index;
   logic [CSR_DATA_W-1:0]     csr_wdata;
   logic                      req_valid;
   logic                      req_ready;
   logic signed [COORD_W-1:0] req_start_x, req_ctrl_one_x, req_ctrl_two_x, req_end_x;
   logic signed [COORD_W-1:0] req_start_y, req_ctrl_one_y, req_ctrl_two_y, req_end_y;
   logic                      req_restart_bounds;
   logic                      rsp_valid;
   logic                      rsp_ready;
   logic signed [COORD_W-1:0] rsp_point_x, rsp_point_y;
   logic                      rsp_last_point;
   logic signed [COORD_W-1:0] rsp_min_x, rsp_min_y, rsp_max_x, rsp_max_y;

   bezier_scoreboard_type sb;
   bit                    calm;
   int                    cycles;

   cubic_bezier_forward_difference dut (
      .clock              (clock),
      .reset              (reset),
      .csr_we             (csr_we),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_start_x        (req_start_x),
      .req_ctrl_one_x     (req_ctrl_one_x),
      .req_ctrl_two_x     (req_ctrl_two_x),
      .req_end_x          (req_end_x),
      .req_start_y        (req_start_y),
      .req_ctrl_one_y     (req_ctrl_one_y),
      .req_ctrl_two_y     (req_ctrl_two_y),
      .req_end_y          (req_end_y),
      .req_restart_bounds (req_restart_bounds),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_point_x        (rsp_point_x),
      .rsp_point_y        (rsp_point_y),
      .rsp_last_point     (rsp_last_point),
      .rsp_min_x          (rsp_min_x),
      .rsp_min_y          (rsp_min_y),
      .rsp_max_x          (rsp_max_x),
      .rsp_max_y          (rsp_max_y)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // result side back-pressure
   always @(posedge clock) begin
      rsp_ready <= calm || ($urandom_range(99) >= 32);
   end

   always @(posedge clock) begin
      vertex_type got;
      if (!reset && rsp_valid && rsp_ready) begin
         got.point_x = rsp_point_x;
         got.point_y = rsp_point_y;
         got.last    = rsp_last_point;
         got.min_x   = rsp_min_x;
         got.min_y   = rsp_min_y;
         got.max_x   = rsp_max_x;
         got.max_y   = rsp_max_y;
         sb.check_vertex(got);
      end
   end

   function automatic int rand_coord();
      case ($urandom_range(9))
         0:       return -32768;
         1:       return 32767;
         2, 3:    return int'($urandom_range(200)) - 100;
         default: return int'($signed(16'($urandom)));
      endcase
   endfunction

   task automatic send_curve(curve_type c);
      int idle;
      idle = 0;
      if (!calm) while ($urandom_range(99) < 32) idle++;
      if (idle > 0) begin
         req_valid <= 1'b0;
         repeat (idle) @(posedge clock);
      end
      req_valid          <= 1'b1;
      req_start_x        <= c.sx;
      req_ctrl_one_x     <= c.c1x;
      req_ctrl_two_x     <= c.c2x;
      req_end_x          <= c.ex;
      req_start_y        <= c.sy;
      req_ctrl_one_y     <= c.c1y;
      req_ctrl_two_y     <= c.c2y;
      req_end_y          <= c.ey;
      req_restart_bounds <= c.restart;
      do @(posedge clock); while (!req_ready);
      sb.note_curve(c);
   endtask

   task automatic send_coords(int sx, int c1x, int c2x, int ex, int sy, int c1y, int c2y,
                              int ey, bit restart);
      curve_type c;
      c.sx      = COORD_W'(sx);
      c.c1x     = COORD_W'(c1x);
      c.c2x     = COORD_W'(c2x);
      c.ex      = COORD_W'(ex);
      c.sy      = COORD_W'(sy);
      c.c1y     = COORD_W'(c1y);
      c.c2y     = COORD_W'(c2y);
      c.ey      = COORD_W'(ey);
      c.restart = restart;
      send_curve(c);
   endtask

   // drain all words and let the block settle before touching registers
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (16) @(posedge clock);
   endtask

   task automatic apply_setting(logic [CSR_DATA_W-1:0] qual, logic [CSR_DATA_W-1:0] pre);
      csr_we    <= 1'b1;
      csr_index <= CSR_QUALITY;
      csr_wdata <= qual;
      sb.write_reg(CSR_QUALITY, qual);
      @(posedge clock);
      csr_index <= CSR_PRESCALE_OFF;
      csr_wdata <= pre;
      sb.write_reg(CSR_PRESCALE_OFF, pre);
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   initial begin
      logic [CSR_DATA_W-1:0] qual_tab [NUM_PHASES];
      bit                    pre_tab  [NUM_PHASES];
      curve_type             c;
      int                    ph, i;
      qual_tab = '{3'd0, 3'd7, 3'd5, 3'd1, 3'd3, 3'd6, 3'd2, 3'd4, 3'd0, 3'd5};
      pre_tab  = '{1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0};
      sb                 = new();
      cycles             = 0;
      calm               = 1'b0;
      reset              = 1'b1;
      csr_we             = 1'b0;
      csr_index          = CSR_QUALITY;
      csr_wdata          = '0;
      req_valid          = 1'b0;
      req_start_x        = '0;
      req_ctrl_one_x     = '0;
      req_ctrl_two_x     = '0;
      req_end_x          = '0;
      req_start_y        = '0;
      req_ctrl_one_y     = '0;
      req_ctrl_two_y     = '0;
      req_end_y          = '0;
      req_restart_bounds = 1'b0;
      rsp_ready          = 1'b0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: default setting
      apply_setting(QUALITY_RESET, 3'd0);
      send_coords(0, 0, 0, 0, 0, 0, 0, 0, 1'b1);
      send_coords(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 1'b0);
      send_coords(-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768, 1'b1);
      send_coords(-32768, 32767, -32768, 32767, 32767, -32768, 32767, -32768, 1'b0);
      send_coords(32767, -32768, 32767, -32768, -32768, 32767, -32768, 32767, 1'b1);
      // all-negative curve keeps max at zero
      send_coords(-100, -2000, -30000, -5, -7, -32768, -1, -900, 1'b1);
      send_coords(1, 2, 3, 4, -1, -2, -3, -4, 1'b1);
      send_coords(0, 32767, 32767, 0, -32768, 32767, 32767, -32768, 1'b0);
      send_coords(rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                  rand_coord(), rand_coord(), rand_coord(), rand_coord(), 1'b0);

      // one segment: zero exponent, no rounding term
      wait_idle();
      apply_setting(3'd0, 3'd0);
      send_coords(32767, -32768, 32767, -32768, -32768, 32767, -32768, 32767, 1'b1);
      send_coords(-32768, -32768, 32767, 32767, 5, -5, 5, -5, 1'b0);
      send_coords(rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                  rand_coord(), rand_coord(), rand_coord(), rand_coord(), 1'b1);
      wait_idle();
      apply_setting(3'd0, 3'd1);
      send_coords(-32768, 32767, -32768, 32767, 32767, -32768, 32767, -32768, 1'b0);

      // quality above the cap
      wait_idle();
      apply_setting(3'd7, 3'd7);
      send_coords(-32768, 32767, -32768, 32767, 32767, -32768, 32767, -32768, 1'b1);
      send_coords(rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                  rand_coord(), rand_coord(), rand_coord(), rand_coord(), 1'b0);
      wait_idle();
      apply_setting(3'd6, 3'd6);
      send_coords(32767, -32768, -32768, 32767, -32768, 32767, 32767, -32768, 1'b1);

      // quality one with prescale
      wait_idle();
      apply_setting(3'd1, 3'd0);
      send_coords(32767, -32768, 32767, -32768, -32768, 32767, -32768, 32767, 1'b1);
      send_coords(-1, 1, -1, 1, 3, -3, 3, -3, 1'b0);

      // random phases
      for (ph = 0; ph < NUM_PHASES; ph++) begin
         wait_idle();
         apply_setting(qual_tab[ph], {2'($urandom_range(3)), pre_tab[ph]});
         calm <= (ph == 4);
         for (i = 0; i < PHASE_ITEMS; i++) begin
            c.sx      = COORD_W'(rand_coord());
            c.c1x     = COORD_W'(rand_coord());
            c.c2x     = COORD_W'(rand_coord());
            c.ex      = COORD_W'(rand_coord());
            c.sy      = COORD_W'(rand_coord());
            c.c1y     = COORD_W'(rand_coord());
            c.c2y     = COORD_W'(rand_coord());
            c.ey      = COORD_W'(rand_coord());
            c.restart = ($urandom_range(3) == 0);
            send_curve(c);
         end
      end

      wait_idle();
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

### files.f
design/bfd_pkg.sv
design/bfd_lane.sv
design/bfd_datapath.sv
design/bfd_ctrl.sv
design/cubic_bezier_forward_difference.sv
tb/tb_cubic_bezier_forward_difference.sv
